/* rtl/lis_pkg.sv */
// Shared constants and types for the longest increasing subsequence block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lis_pkg;

    // Store depth and element width.
    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;

    // Width of the request value field and of the result length fields.
    localparam int IN_W  = 32;
    localparam int LEN_W = 11;

    // Tail slot address and fill count (count must reach MAX_LEN itself).
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    // One input request as seen by the search unit.
    typedef struct packed {
        logic signed [IN_W-1:0] value;
        logic                   last;
    } lis_req_t;

    // One result as produced by the search unit.
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] position;
        logic             overflow;
        logic             final_res;
    } lis_res_t;

endpackage

/* rtl/lis_in_if.sv */
// Input channel interface: valid/ready handshake with the request payload.
// Depends on lis_pkg for the field widths.
`timescale 1ns / 1ps

interface lis_in_if
    import lis_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] value;
    logic                   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

/* rtl/lis_out_if.sv */
// Output channel interface: valid/ready handshake with the result payload.
// Depends on lis_pkg for the field widths.
`timescale 1ns / 1ps

interface lis_out_if
    import lis_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] position;
    logic             overflow;
    logic             final_res;

    modport source (output valid, output length, output position, output overflow,
                    output final_res, input ready);
    modport sink   (input valid, input length, input position, input overflow,
                    input final_res, output ready);
endinterface

/* rtl/longest_increasing_subsequence.sv */
// Top level of the longest strictly increasing subsequence block.
// Depends on lis_pkg, lis_in_if, lis_out_if and lis_search.
//
//   Channel  Dir  Payload                                    Handshake
//   sample   in   value[31:0] signed, last                   valid/ready
//   result   out  length[10:0], position[10:0], overflow,    valid/ready
//                 final_res
//
// A request passes through a start step that issues the first read, one memory
// read and compare per search step, and a write step that stores the tail.
// Reset clears the fill count; the tail memory needs no clearing.
// A result waiting in the output register does not hold up the next search;
// only a second finished result stalls until the first is taken.
`timescale 1ns / 1ps

module longest_increasing_subsequence
    import lis_pkg::*;
(
    input logic clk,
    input logic rst_n,
    lis_in_if.sink    sample,
    lis_out_if.source result
);

    lis_req_t req;
    lis_res_t res;
    logic     res_valid;
    logic     res_ready;

    logic     out_valid_reg, out_valid_next;
    lis_res_t out_reg;

    assign req.value = sample.value;
    assign req.last  = sample.last;

    lis_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (sample.valid),
        .req_ready (sample.ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or when its result is being taken.
    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.length    = out_reg.length;
    assign result.position  = out_reg.position;
    assign result.overflow  = out_reg.overflow;
    assign result.final_res = out_reg.final_res;

endmodule

/* rtl/lis_tail_store.sv */
// Tail value memory: one write port and one read port with registered data.
// Depends on lis_pkg for depth and width.
`timescale 1ns / 1ps

module lis_tail_store
    import lis_pkg::*;
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic signed [VALUE_BITS-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic signed [VALUE_BITS-1:0] wr_data
);

    logic signed [VALUE_BITS-1:0] mem [MAX_LEN];
    logic signed [VALUE_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lis_search.sv */
// Lower-bound search sequencer: one compare against one stored tail per cycle,
// then at most a single write of the new tail. Depends on lis_pkg and lis_tail_store.
`timescale 1ns / 1ps

module lis_search
    import lis_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lis_req_t req,
    output logic     res_valid,
    input  logic     res_ready,
    output lis_res_t res
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_WRITE  = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             hi_reg, hi_next;
    logic [ADDR_W-1:0]            mid_reg, mid_next;
    logic [CNT_W-1:0]             filled_reg, filled_next;
    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    logic                         last_reg, last_next;

    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic signed [VALUE_BITS-1:0] rd_data;
    logic                         wr_en;

    logic                         tail_less;
    logic [CNT_W-1:0]             lo_cmp;
    logic [CNT_W-1:0]             hi_cmp;
    logic [CNT_W-1:0]             mid_cmp;
    logic                         store_full;
    logic [CNT_W-1:0]             lo_plus;
    logic [CNT_W-1:0]             filled_upd;
    logic                         res_fire;

    lis_tail_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (lo_reg[ADDR_W-1:0]),
        .wr_data (key_reg)
    );

    // Shared compare unit: the tail read last cycle against the search key.
    always_comb
    begin
        tail_less = rd_data < key_reg;
        lo_cmp    = tail_less ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
        hi_cmp    = tail_less ? hi_reg : CNT_W'(mid_reg);
        mid_cmp   = lo_cmp + ((hi_cmp - lo_cmp) >> 1);
    end

    // Placement of the new tail once the search has settled.
    always_comb
    begin
        store_full = lo_reg >= CNT_W'(MAX_LEN);
        lo_plus    = lo_reg + CNT_W'(1);
        filled_upd = (!store_full && lo_reg >= filled_reg) ? lo_plus : filled_reg;
        res_fire   = (state_reg == ST_WRITE) && res_ready;
        wr_en      = res_fire && !store_full;
    end

    // Result fields, valid while the sequencer waits in the write state.
    always_comb
    begin
        res_valid     = state_reg == ST_WRITE;
        res.length    = LEN_W'(filled_upd);
        res.position  = store_full ? '0 : LEN_W'(lo_plus);
        res.overflow  = store_full;
        res.final_res = last_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        filled_next = filled_reg;
        key_next    = key_reg;
        last_next   = last_reg;
        req_ready   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = mid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    key_next  = req.value[VALUE_BITS-1:0];
                    last_next = req.last;
                    lo_next   = '0;
                    hi_next   = filled_reg;
                    mid_next  = filled_reg[CNT_W-1:1];
                    if (filled_reg == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = filled_reg[CNT_W-1:1];
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                lo_next = lo_cmp;
                hi_next = hi_cmp;
                if (lo_cmp < hi_cmp)
                begin
                    mid_next = mid_cmp[ADDR_W-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = mid_cmp[ADDR_W-1:0];
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (res_ready)
                begin
                    filled_next = last_reg ? '0 : filled_upd;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            filled_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
        end
    end

    // Search bounds and the held request.
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        last_reg <= last_next;
    end

endmodule
